@@ design/scfmd_pkg.sv @@
package scfmd_pkg;

	// byte codes on the serial link
	localparam logic [7:0] START_MARK = 8'hAA;
	localparam logic [7:0] END_MARK   = 8'hFF;
	localparam logic [7:0] CMD_SPEED  = 8'h01;
	localparam logic [7:0] CMD_HALT   = 8'h02;
	localparam logic [7:0] CMD_ODOM   = 8'h03;

	// frame length bookkeeping (length counts the start byte)
	localparam int unsigned LEN_W           = 4;
	localparam logic [LEN_W-1:0] LEN_START  = 4'd1;
	localparam logic [LEN_W-1:0] LEN_CMD    = 4'd1;
	localparam logic [LEN_W-1:0] LEN_PAY_LO = 4'd2;
	localparam logic [LEN_W-1:0] LEN_PAY_HI = 4'd9;
	localparam logic [LEN_W-1:0] LEN_MAX    = 4'd15;
	localparam logic [LEN_W-1:0] LEN_SPEED  = 4'd12;

	localparam int unsigned PAY_DEPTH = 8;
	localparam int unsigned PAY_IDX_W = $clog2(PAY_DEPTH);

	// speed magnitude before clamping never exceeds 16 bits
	localparam int unsigned MAG_W            = 16;
	localparam int unsigned DUTY_MAX_DEFAULT = 255;

	localparam int unsigned DATA_IN_W  = 8;
	localparam int unsigned DATA_OUT_W = 24;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_SPEED   = 3'd1,
		ST_BRAKE   = 3'd2,
		ST_ODOM    = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic       forward;
		logic [7:0] duty;
	} drive_t;

endpackage

@@ design/scfmd_drive.sv @@
// IEEE single speed target -> direction and clamped duty.
module scfmd_drive #(
	parameter int unsigned DUTY_MAX = scfmd_pkg::DUTY_MAX_DEFAULT
) (
	input  logic                  brake,
	input  logic [31:0]           target,
	output scfmd_pkg::drive_t     drive
);

	localparam logic [scfmd_pkg::MAG_W-1:0] DutyMaxW = scfmd_pkg::MAG_W'(DUTY_MAX);
	localparam logic [7:0] ExpOne   = 8'd127;
	localparam logic [7:0] ExpSat   = 8'd143; // 2^16 and up, inf, NaN
	localparam logic [7:0] ExpShift = 8'd150;

	logic                          sign;
	logic [7:0]                    ex;
	logic [23:0]                   sig;
	logic [4:0]                    sh;
	logic [23:0]                   shifted;
	logic [scfmd_pkg::MAG_W-1:0]   mag;
	logic [scfmd_pkg::MAG_W-1:0]   clamped;

	always_comb begin
		sign    = target[31];
		ex      = target[30:23];
		sig     = {1'b1, target[22:0]};
		sh      = 5'(ExpShift - ex);
		shifted = sig >> sh;
		mag     = shifted[scfmd_pkg::MAG_W-1:0];

		priority if (ex >= ExpSat) begin
			clamped = DutyMaxW;
		end else if (ex < ExpOne) begin
			clamped = '0;
		end else if (mag > DutyMaxW) begin
			clamped = DutyMaxW;
		end else begin
			clamped = mag;
		end

		if (brake) begin
			drive.forward = 1'b0;
			drive.duty    = '0;
		end else begin
			drive.forward = (clamped == '0) || !sign;
			drive.duty    = clamped[7:0];
		end
	end

endmodule

@@ design/serial_command_frame_motor_drive_core.sv @@
// Serial command framer with a two-motor drive stage.
//
// Input stream (s_*): one received UART byte per item in s_tdata[7:0].
// A frame opens on 0xAA while idle and closes on the first 0xFF; the
// second frame byte is the command. Speed frames (0x01, 12 bytes) load
// two little-endian IEEE single targets, 0x02 brakes, 0x03 only reports.
// Output stream (m_*): exactly one item per input byte, giving the drive
// after that byte (direction and duty per motor, brake flag, frame status).
// Speeds truncate toward zero, clamp to DUTY_MAX, and zero drives forward.
//
// An accepted byte lands in the input register, and its result in the
// result register. Throughput: one item per cycle while m_tready is
// high; the frame state updates and both float converters sit in the
// single stage between the two registers.
// Stall: when m_tready is low the result register holds; one more byte
// may sit in the input register, after which s_tready drops.
// Reset (arst_n low): no frame open, targets +0, brake off, both
// registers empty.
module serial_command_frame_motor_drive_core #(
	parameter int unsigned DUTY_MAX = scfmd_pkg::DUTY_MAX_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [7:0] rx_byte
	input  logic [scfmd_pkg::DATA_IN_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] left_forward, [8:1] left_duty, [9] right_forward, [17:10] right_duty,
	// [18] braking, [21:19] frame_status, [23:22] zero
	output logic [scfmd_pkg::DATA_OUT_W-1:0] m_tdata
);

	// handshake / pipeline
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	logic [scfmd_pkg::DATA_OUT_W-1:0] res_s2;
	logic       adv;
	logic       step;

	// frame state
	logic                        in_frame_q;
	logic [scfmd_pkg::LEN_W-1:0] len_q;
	logic [7:0]                  cmd_q;
	logic [7:0]                  payload_q [scfmd_pkg::PAY_DEPTH];
	logic [31:0]                 left_tgt_q;
	logic [31:0]                 right_tgt_q;
	logic                        brake_q;

	// next state
	logic                        in_frame_d;
	logic [scfmd_pkg::LEN_W-1:0] len_d;
	logic [31:0]                 left_tgt_d;
	logic [31:0]                 right_tgt_d;
	logic                        brake_d;
	logic                        cmd_wr;
	logic                        pay_wr;
	logic [scfmd_pkg::PAY_IDX_W-1:0] pay_idx;
	logic [7:0]                  cmd_eff;
	scfmd_pkg::status_t          status;

	scfmd_pkg::drive_t           left_drv;
	scfmd_pkg::drive_t           right_drv;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	assign pay_idx = scfmd_pkg::PAY_IDX_W'(len_q - scfmd_pkg::LEN_PAY_LO);

	always_comb begin
		in_frame_d  = in_frame_q;
		len_d       = len_q;
		left_tgt_d  = left_tgt_q;
		right_tgt_d = right_tgt_q;
		brake_d     = brake_q;
		cmd_wr      = 1'b0;
		pay_wr      = 1'b0;
		status      = scfmd_pkg::ST_NONE;
		// command byte arriving now also counts for an "AA FF" early close
		cmd_eff     = (len_q == scfmd_pkg::LEN_CMD) ? byte_s1 : cmd_q;

		if (!in_frame_q) begin
			if (byte_s1 == scfmd_pkg::START_MARK) begin
				in_frame_d = 1'b1;
				len_d      = scfmd_pkg::LEN_START;
			end
		end else begin
			cmd_wr = (len_q == scfmd_pkg::LEN_CMD);
			pay_wr = (len_q >= scfmd_pkg::LEN_PAY_LO) && (len_q <= scfmd_pkg::LEN_PAY_HI);
			if (len_q != scfmd_pkg::LEN_MAX) begin
				len_d = len_q + 1'b1;
			end
			if (byte_s1 == scfmd_pkg::END_MARK) begin
				in_frame_d = 1'b0;
				unique case (cmd_eff)
					scfmd_pkg::CMD_SPEED: begin
						if (len_d == scfmd_pkg::LEN_SPEED) begin
							left_tgt_d  = {payload_q[3], payload_q[2],
							               payload_q[1], payload_q[0]};
							right_tgt_d = {payload_q[7], payload_q[6],
							               payload_q[5], payload_q[4]};
							brake_d     = 1'b0;
							status      = scfmd_pkg::ST_SPEED;
						end else begin
							status = scfmd_pkg::ST_IGNORED;
						end
					end
					scfmd_pkg::CMD_HALT: begin
						brake_d     = 1'b1;
						left_tgt_d  = '0;
						right_tgt_d = '0;
						status      = scfmd_pkg::ST_BRAKE;
					end
					scfmd_pkg::CMD_ODOM: begin
						status = scfmd_pkg::ST_ODOM;
					end
					default: begin
						status = scfmd_pkg::ST_IGNORED;
					end
				endcase
			end
		end
	end

	scfmd_drive #(.DUTY_MAX(DUTY_MAX)) u_drive_left (
		.brake  (brake_d),
		.target (left_tgt_d),
		.drive  (left_drv)
	);

	scfmd_drive #(.DUTY_MAX(DUTY_MAX)) u_drive_right (
		.brake  (brake_d),
		.target (right_tgt_d),
		.drive  (right_drv)
	);

	// control and state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			in_frame_q  <= 1'b0;
			len_q       <= '0;
			left_tgt_q  <= '0;
			right_tgt_q <= '0;
			brake_q     <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				in_frame_q  <= in_frame_d;
				len_q       <= len_d;
				left_tgt_q  <= left_tgt_d;
				right_tgt_q <= right_tgt_d;
				brake_q     <= brake_d;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
		end
		if (step) begin
			res_s2 <= {2'b00, status, brake_d,
			           right_drv.duty, right_drv.forward,
			           left_drv.duty, left_drv.forward};
			if (cmd_wr) begin
				cmd_q <= byte_s1;
			end
			if (pay_wr) begin
				payload_q[pay_idx] <= byte_s1;
			end
		end
	end

endmodule

@@ design/scfmd_chk.sv @@
// Port-level checks on the result stream.
module scfmd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic       l_fwd;
	logic [7:0] l_duty;
	logic       r_fwd;
	logic [7:0] r_duty;
	logic       brk;
	logic [2:0] st;

	assign l_fwd  = m_tdata[0];
	assign l_duty = m_tdata[8:1];
	assign r_fwd  = m_tdata[9];
	assign r_duty = m_tdata[17:10];
	assign brk    = m_tdata[18];
	assign st     = m_tdata[21:19];

	// braking forces both motors to reverse-flagged zero duty
	a_brake_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && brk) |-> (!l_fwd && !r_fwd && l_duty == 8'd0 && r_duty == 8'd0))
		else $error("drive active while braking");

	// brake frame sets the flag, a speed frame clears it
	a_status_brake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((st != scfmd_pkg::ST_BRAKE || brk)
			&& (st != scfmd_pkg::ST_SPEED || !brk)))
		else $error("brake flag disagrees with frame status");

	// zero duty outside braking always drives forward
	a_zero_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !brk) |-> ((l_duty != 8'd0 || l_fwd) && (r_duty != 8'd0 || r_fwd)))
		else $error("zero duty with reverse direction");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed under stall");

endmodule

bind serial_command_frame_motor_drive_core scfmd_chk u_scfmd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/scfmd_drive_checker.sv @@
// Watches both streams of the frame/drive core, predicts one drive item per
// accepted byte and compares each output item against the oldest prediction.
module scfmd_drive_checker #(
	parameter int unsigned DUTY_MAX = scfmd_pkg::DUTY_MAX_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [scfmd_pkg::DATA_IN_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [scfmd_pkg::DATA_OUT_W-1:0] m_tdata,
	output int                               errors,
	output int                               pending,
	output int                               checked
);
	import scfmd_pkg::*;

	typedef struct packed {
		drive_t  left;
		drive_t  right;
		logic    braking;
		status_t status;
	} drive_result_t;

	drive_result_t drive_q[$];
	drive_result_t want;

	// predictor state
	logic             in_frame  = 1'b0;
	logic [LEN_W-1:0] frame_len = '0;
	logic [7:0]       cmd_byte  = '0;
	logic [7:0]       payload [PAY_DEPTH];
	logic [31:0]      left_tgt    = '0;
	logic [31:0]      right_tgt   = '0;
	logic             brake_on    = 1'b0;

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	// truncate toward zero, clamp magnitude, zero result drives forward
	function automatic drive_t float_to_drive(input logic [31:0] bits);
		drive_t      d;
		int unsigned mag;
		int unsigned ex;
		ex = bits[30:23];
		if (ex >= 143)
			mag = 32'h1_0000;
		else if (ex < 127)
			mag = 0;
		else
			mag = {9'd1, bits[22:0]} >> (150 - ex);
		if (mag > DUTY_MAX)
			mag = DUTY_MAX;
		d.forward = (mag == 0) || !bits[31];
		d.duty    = mag[7:0];
		return d;
	endfunction

	function automatic drive_result_t frame_step(input logic [7:0] b);
		drive_result_t r;
		r.status = ST_NONE;
		if (!in_frame) begin
			if (b == START_MARK) begin
				in_frame  = 1'b1;
				frame_len = LEN_START;
			end
		end else begin
			if (frame_len == LEN_CMD)
				cmd_byte = b;
			else if (frame_len >= LEN_PAY_LO && frame_len <= LEN_PAY_HI)
				payload[frame_len - LEN_PAY_LO] = b;
			if (frame_len < LEN_MAX)
				frame_len = frame_len + 1'b1;
			if (b == END_MARK) begin
				case (cmd_byte)
					CMD_SPEED: begin
						if (frame_len == LEN_SPEED) begin
							left_tgt  = {payload[3], payload[2], payload[1], payload[0]};
							right_tgt = {payload[7], payload[6], payload[5], payload[4]};
							brake_on  = 1'b0;
							r.status  = ST_SPEED;
						end else begin
							r.status = ST_IGNORED;
						end
					end
					CMD_HALT: begin
						brake_on  = 1'b1;
						left_tgt  = '0;
						right_tgt = '0;
						r.status  = ST_BRAKE;
					end
					CMD_ODOM: r.status = ST_ODOM;
					default:  r.status = ST_IGNORED;
				endcase
				in_frame = 1'b0;
			end
		end
		if (brake_on) begin
			r.left  = '0;
			r.right = '0;
		end else begin
			r.left  = float_to_drive(left_tgt);
			r.right = float_to_drive(right_tgt);
		end
		r.braking = brake_on;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame    = 1'b0;
			frame_len   = '0;
			left_tgt    = '0;
			right_tgt   = '0;
			brake_on    = 1'b0;
			drive_q.delete();
			pending     = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					$error("drive item 0x%06h arrived with nothing expected", m_tdata);
					errors++;
				end else begin
					want = drive_q.pop_front();
					check_field("left_forward", want.left.forward, m_tdata[0]);
					check_field("left_duty", want.left.duty, m_tdata[8:1]);
					check_field("right_forward", want.right.forward, m_tdata[9]);
					check_field("right_duty", want.right.duty, m_tdata[17:10]);
					check_field("braking", want.braking, m_tdata[18]);
					check_field("frame_status", want.status, m_tdata[21:19]);
					check_field("pad", 0, m_tdata[23:22]);
					checked++;
				end
			end
			if (s_tvalid && s_tready)
				drive_q.push_back(frame_step(s_tdata));
			pending = drive_q.size();
		end
	end

endmodule

@@ tb/tb_serial_command_frame_motor_drive_core.sv @@
// Top of the bench for the serial command framer / motor drive core.
// Stimulus only: bytes go in on the s_* stream, the m_* stream is drained
// with random stalls. All prediction and comparison live in the checker.
module tb_serial_command_frame_motor_drive_core;
	import scfmd_pkg::*;

	localparam int RAND_BYTES  = 800;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [DATA_IN_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_OUT_W-1:0] m_tdata;

	int errors;
	int pending;
	int checked;

	// when set, both sides run back to back with no idle cycles
	logic steady = 1'b0;

	int n_bytes  = 0;
	int n_frames = 0;
	int n_speed  = 0;
	int n_stray  = 0;

	logic [7:0] frame_bytes[$];

	always #5 clk = ~clk;

	serial_command_frame_motor_drive_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	scfmd_drive_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	// Send one byte. Entered at a falling edge, returns at a falling edge.
	// With no gap, valid simply stays high and only the data changes.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_bytes++;
	endtask

	task automatic flush_frame();
		while (frame_bytes.size() > 0)
			send_byte(frame_bytes.pop_front());
	endtask

	// any byte except the end mark, so it can't close a frame
	function automatic logic [7:0] data_byte();
		return 8'($urandom_range(0, 254));
	endfunction

	task automatic push_word(input logic [31:0] w);
		frame_bytes.push_back(w[7:0]);
		frame_bytes.push_back(w[15:8]);
		frame_bytes.push_back(w[23:16]);
		frame_bytes.push_back(w[31:24]);
	endtask

	// Speed value biased toward the interesting exponent bands: below one,
	// the 1..65535 conversion range, overflow, inf/NaN and signed zeros.
	// Bytes equal to the end mark are nudged down, since they'd end the frame.
	function automatic logic [31:0] speed_bits();
		logic [31:0] w;
		logic [7:0]  ex;
		int          cat;
		cat   = $urandom_range(0, 9);
		w     = $urandom;
		w[31] = $urandom_range(0, 1);
		case (cat)
			0:       ex = 8'($urandom_range(0, 126));
			6:       ex = 8'($urandom_range(143, 254));
			7:       ex = 8'hFF;
			8:       ex = 8'h00;
			9:       ex = w[30:23];
			default: ex = 8'($urandom_range(127, 142));
		endcase
		w[30:23] = ex;
		if (cat == 8 || $urandom_range(0, 7) == 0)
			w[22:0] = '0;
		for (int i = 0; i < 4; i++)
			if (w[8*i +: 8] == END_MARK)
				w[8*i +: 8] = 8'($urandom_range(0, 254));
		return w;
	endfunction

	// well-formed 12-byte speed frame; checksum byte is never checked
	task automatic build_speed(input logic [31:0] lw, input logic [31:0] rw);
		frame_bytes.push_back(START_MARK);
		frame_bytes.push_back(CMD_SPEED);
		push_word(lw);
		push_word(rw);
		frame_bytes.push_back(data_byte());
		frame_bytes.push_back(END_MARK);
		n_frames++;
		n_speed++;
	endtask

	// start mark, command, n data bytes, end mark; an end-mark command stops there
	task automatic build_frame(input logic [7:0] cmd, input int n);
		frame_bytes.push_back(START_MARK);
		frame_bytes.push_back(cmd);
		if (cmd != END_MARK) begin
			repeat (n) frame_bytes.push_back(data_byte());
			frame_bytes.push_back(END_MARK);
		end
		n_frames++;
	endtask

	// Sink side: per item a random stall (none when steady), then wait for the item.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles, %0d items still expected", CYCLE_LIMIT, pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int kind;
		int n;
		int cut;
		logic [7:0] cmd;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed ----
		// stray bytes while idle: 0x00 and 0x55
		send_byte(8'h00);
		send_byte(8'h55);
		n_stray += 2;
		// early close: end mark lands in the command slot
		build_frame(END_MARK, 0);
		// odometry frame, only a status
		build_frame(CMD_ODOM, 0);
		// left +inf saturates, right exactly 255.0
		build_speed(32'h7F80_0000, 32'h437F_0000);
		// brake: targets cleared, duty 0 in reverse
		build_frame(CMD_HALT, 0);
		flush_frame();
		// stray end mark while idle
		send_byte(END_MARK);
		n_stray++;

		// ---- random ----
		while (n_bytes < RAND_BYTES + 23) begin
			if ($urandom_range(0, 40) == 0)
				steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				build_speed(speed_bits(), speed_bits());
			end else if (kind < 60) begin
				build_frame(CMD_HALT, $urandom_range(0, 4));
			end else if (kind < 67) begin
				build_frame(CMD_ODOM, $urandom_range(0, 4));
			end else if (kind < 75) begin
				// wrong length speed frame: short, long, or past the length saturation
				do n = $urandom_range(0, 20); while (n == 9);
				build_frame(CMD_SPEED, n);
			end else if (kind < 83) begin
				do cmd = 8'($urandom); while (cmd == CMD_SPEED || cmd == CMD_HALT ||
					cmd == CMD_ODOM);
				build_frame(cmd, $urandom_range(0, 12));
			end else if (kind < 90) begin
				// speed frame cut short by an end mark in its body;
				// the tail then arrives after the frame has closed
				build_speed(speed_bits(), speed_bits());
				cut = $urandom_range(2, 10);
				frame_bytes[cut] = END_MARK;
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) frame_bytes.push_back(8'($urandom));
				n_stray += n;
			end
			flush_frame();
		end
		s_tvalid = 1'b0;
		steady   = 1'b0;

		// drain, then wait on for anything spurious
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Sent %0d bytes: %0d frames (%0d speed frames) and %0d stray bytes",
			n_bytes, n_frames, n_speed, n_stray);
		$display("Checked %0d drive items, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
design/scfmd_pkg.sv
design/scfmd_drive.sv
design/serial_command_frame_motor_drive_core.sv
design/scfmd_chk.sv
tb/scfmd_drive_checker.sv
tb/tb_serial_command_frame_motor_drive_core.sv
